### sv/mmtes_pkg.sv
// Package for the multi-mode timer slot table: sizes, payload types, codes
// and small helper functions. It depends on nothing else.
package mmtes_pkg;

    localparam int SLOTS     = 8;
    localparam int TIME_BITS = 32;
    localparam int SLOT_W    = $clog2(SLOTS);
    localparam int MAX_OUT   = 8;
    localparam int CNT_W     = $clog2(MAX_OUT + 1);
    localparam int COND_BITS = 8;

    typedef struct packed {
        logic        kind;
        logic [1:0]  mode;
        logic [31:0] time_point;
        logic [31:0] period_ticks;
        logic [7:0]  condition_bits;
    } t_in_item;

    typedef struct packed {
        logic [1:0] event_res;
        logic [2:0] slot_index;
        logic       last;
    } t_out_item;

    typedef enum logic {
        OP_TICK     = 1'b0,
        OP_REGISTER = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        MODE_ONESHOT  = 2'd0,
        MODE_PERIODIC = 2'd1,
        MODE_UNTIL    = 2'd2,
        MODE_WHILE    = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        EV_FIRED      = 2'd0,
        EV_REGISTERED = 2'd1,
        EV_FULL       = 2'd2
    } t_event;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH
    } t_back_state;

    typedef struct packed {
        t_op                  op;
        logic [1:0]           mode;
        logic [TIME_BITS-1:0] time_point;
        logic [TIME_BITS-1:0] period;
        logic [COND_BITS-1:0] cond;
    } t_cmd;

    typedef struct packed {
        logic [1:0]           mode;
        logic [TIME_BITS-1:0] end_time;
        logic [TIME_BITS-1:0] next_due;
        logic [TIME_BITS-1:0] period;
    } t_slot_word;

    localparam int SLOT_WORD_W = $bits(t_slot_word);

    function automatic logic [TIME_BITS-1:0] to_time(input logic [31:0] v);
        logic [95:0] w;
        w = {64'd0, v};
        return w[TIME_BITS-1:0];
    endfunction

    function automatic logic is_due(input logic [TIME_BITS-1:0] deadline,
                                    input logic [TIME_BITS-1:0] now);
        logic [TIME_BITS-1:0] d;
        d = deadline - now;
        return (d == '0) || d[TIME_BITS-1];
    endfunction

    function automatic logic [2:0] slot_out(input logic [SLOT_W-1:0] idx);
        logic [7:0] w;
        w = 8'(idx);
        return w[2:0];
    endfunction

    function automatic logic cond_of(input logic [COND_BITS-1:0] cond,
                                     input logic [SLOT_W-1:0] idx);
        logic [7:0] w;
        w = 8'(idx);
        return (w < 8'(COND_BITS)) ? cond[w[2:0]] : 1'b0;
    endfunction

endpackage

### sv/mmtes_ram.sv
// Generic single-write, single-read memory with a registered read port.
// It depends on nothing else.
module mmtes_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### sv/mmtes_front.sv
// Front end: takes requests, decodes them into commands and queues them
// for the back end in a two-entry queue. Depends on mmtes_pkg.
module mmtes_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    output logic              o_full,
    input  mmtes_pkg::t_in_item i_req,
    output logic              o_cmd_vld,
    input  logic              i_cmd_pop,
    output mmtes_pkg::t_cmd   o_cmd
);

    mmtes_pkg::t_cmd r_mem [2];
    logic            r_wp;
    logic            r_rp;
    logic [1:0]      r_cnt;
    logic            n_wp;
    logic            n_rp;
    logic [1:0]      n_cnt;
    mmtes_pkg::t_cmd w_cmd;
    logic            w_wr;
    logic            w_rd;

    always_comb begin
        w_cmd.op         = i_req.kind ? mmtes_pkg::OP_REGISTER : mmtes_pkg::OP_TICK;
        w_cmd.mode       = i_req.mode;
        w_cmd.time_point = mmtes_pkg::to_time(i_req.time_point);
        w_cmd.period     = mmtes_pkg::to_time(i_req.period_ticks);
        w_cmd.cond       = i_req.condition_bits;
    end

    assign w_wr = i_push && (r_cnt != 2'd2);
    assign w_rd = i_cmd_pop && (r_cnt != 2'd0);

    always_comb begin
        n_wp  = w_wr ? ~r_wp : r_wp;
        n_rp  = w_rd ? ~r_rp : r_rp;
        n_cnt = r_cnt + 2'(w_wr) - 2'(w_rd);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= w_cmd;
        end
    end

    assign o_full    = (r_cnt == 2'd2);
    assign o_cmd_vld = (r_cnt != 2'd0);
    assign o_cmd     = r_mem[r_rp];

endmodule

### sv/mmtes_out_q.sv
// Result queue: two entries between the back end and the result port.
// Depends on mmtes_pkg.
module mmtes_out_q (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  mmtes_pkg::t_out_item i_res,
    output logic                 o_full,
    output logic                 o_empty,
    input  logic                 i_pop,
    output mmtes_pkg::t_out_item o_res
);

    mmtes_pkg::t_out_item r_mem [2];
    logic                 r_wp;
    logic                 r_rp;
    logic [1:0]           r_cnt;
    logic                 w_wr;
    logic                 w_rd;

    assign w_wr = i_push && (r_cnt != 2'd2);
    assign w_rd = i_pop && (r_cnt != 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_wr) begin
                r_wp <= ~r_wp;
            end
            if (w_rd) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(w_wr) - 2'(w_rd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= i_res;
        end
    end

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_res   = r_mem[r_rp];

endmodule

### sv/mmtes_back.sv
// Back end: the time counter, the slot valid bits and the sequencer that
// registers timers and scans the slot memory on each tick. Depends on mmtes_pkg.
module mmtes_back (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cmd_vld,
    input  mmtes_pkg::t_cmd                      i_cmd,
    output logic                                 o_cmd_pop,
    input  logic                                 i_res_full,
    output logic                                 o_res_push,
    output mmtes_pkg::t_out_item                 o_res,
    output logic                                 o_ram_we,
    output logic [mmtes_pkg::SLOT_W-1:0]         o_ram_waddr,
    output logic [mmtes_pkg::SLOT_WORD_W-1:0]    o_ram_wdata,
    output logic                                 o_ram_re,
    output logic [mmtes_pkg::SLOT_W-1:0]         o_ram_raddr,
    input  logic [mmtes_pkg::SLOT_WORD_W-1:0]    i_ram_rdata
);

    mmtes_pkg::t_back_state r_state;
    mmtes_pkg::t_back_state n_state;

    logic [mmtes_pkg::TIME_BITS-1:0] r_time;
    logic [mmtes_pkg::TIME_BITS-1:0] n_time;
    logic [mmtes_pkg::SLOTS-1:0]     r_valid;
    logic [mmtes_pkg::SLOTS-1:0]     n_valid;
    logic [mmtes_pkg::COND_BITS-1:0] r_cond;
    logic [mmtes_pkg::COND_BITS-1:0] n_cond;
    logic [mmtes_pkg::SLOT_W:0]      r_issue;
    logic [mmtes_pkg::SLOT_W:0]      n_issue;
    logic                            r_eval_vld;
    logic                            n_eval_vld;
    logic [mmtes_pkg::SLOT_W-1:0]    r_eval_idx;
    logic [mmtes_pkg::SLOT_W-1:0]    n_eval_idx;
    logic                            r_pend_vld;
    logic                            n_pend_vld;
    logic [mmtes_pkg::SLOT_W-1:0]    r_pend_idx;
    logic [mmtes_pkg::SLOT_W-1:0]    n_pend_idx;
    logic [mmtes_pkg::CNT_W-1:0]     r_cnt;
    logic [mmtes_pkg::CNT_W-1:0]     n_cnt;

    logic                         w_free_found;
    logic [mmtes_pkg::SLOT_W-1:0] w_free_idx;
    mmtes_pkg::t_slot_word        w_rd;
    mmtes_pkg::t_slot_word        w_new;
    mmtes_pkg::t_slot_word        w_wr;
    logic                         w_due;
    logic                         w_end_due;
    logic                         w_fire;
    logic                         w_free;
    logic                         w_advance;

    always_comb begin
        w_free_found = 1'b0;
        w_free_idx   = '0;
        for (int i = mmtes_pkg::SLOTS - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                w_free_found = 1'b1;
                w_free_idx   = mmtes_pkg::SLOT_W'(i);
            end
        end
    end

    always_comb begin
        w_new.mode     = i_cmd.mode;
        w_new.end_time = i_cmd.time_point;
        w_new.period   = i_cmd.period;
        w_new.next_due = (mmtes_pkg::t_mode'(i_cmd.mode) == mmtes_pkg::MODE_ONESHOT) ?
                         i_cmd.time_point : r_time;
    end

    always_comb begin
        w_rd      = mmtes_pkg::t_slot_word'(i_ram_rdata);
        w_due     = mmtes_pkg::is_due(w_rd.next_due, r_time);
        w_end_due = mmtes_pkg::is_due(w_rd.end_time, r_time);
        w_fire    = 1'b0;
        w_free    = 1'b0;
        if (r_valid[r_eval_idx]) begin
            case (mmtes_pkg::t_mode'(w_rd.mode))
                mmtes_pkg::MODE_ONESHOT: begin
                    w_fire = w_due;
                    w_free = w_due;
                end
                mmtes_pkg::MODE_PERIODIC: begin
                    w_fire = w_due;
                end
                mmtes_pkg::MODE_UNTIL: begin
                    w_free = w_end_due;
                    w_fire = !w_end_due && w_due;
                end
                default: begin
                    if (w_due) begin
                        if (mmtes_pkg::cond_of(r_cond, r_eval_idx)) begin
                            w_fire = 1'b1;
                        end else begin
                            w_free = 1'b1;
                        end
                    end
                end
            endcase
        end
        w_wr          = w_rd;
        w_wr.next_due = r_time + w_rd.period;
    end

    assign w_advance = !i_res_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mmtes_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_time      = r_time;
        n_valid     = r_valid;
        n_cond      = r_cond;
        n_issue     = r_issue;
        n_eval_vld  = r_eval_vld;
        n_eval_idx  = r_eval_idx;
        n_pend_vld  = r_pend_vld;
        n_pend_idx  = r_pend_idx;
        n_cnt       = r_cnt;
        o_cmd_pop   = 1'b0;
        o_res_push  = 1'b0;
        o_res       = '0;
        o_ram_we    = 1'b0;
        o_ram_waddr = w_free_idx;
        o_ram_wdata = w_new;
        o_ram_re    = 1'b0;
        o_ram_raddr = r_issue[mmtes_pkg::SLOT_W-1:0];
        case (r_state)
            mmtes_pkg::ST_IDLE: begin
                if (i_cmd_vld && !i_res_full) begin
                    o_cmd_pop = 1'b1;
                    if (i_cmd.op == mmtes_pkg::OP_REGISTER) begin
                        o_res_push = 1'b1;
                        o_res.last = 1'b1;
                        if (w_free_found) begin
                            o_ram_we            = 1'b1;
                            n_valid[w_free_idx] = 1'b1;
                            o_res.event_res     = mmtes_pkg::EV_REGISTERED;
                            o_res.slot_index    = mmtes_pkg::slot_out(w_free_idx);
                        end else begin
                            o_res.event_res = mmtes_pkg::EV_FULL;
                        end
                    end else begin
                        n_time     = r_time + 1'b1;
                        n_cond     = i_cmd.cond;
                        n_issue    = '0;
                        n_eval_vld = 1'b0;
                        n_pend_vld = 1'b0;
                        n_cnt      = '0;
                        n_state    = mmtes_pkg::ST_SCAN;
                    end
                end
            end
            mmtes_pkg::ST_SCAN: begin
                if (w_advance) begin
                    if (r_eval_vld) begin
                        if (w_free) begin
                            n_valid[r_eval_idx] = 1'b0;
                        end
                        if (w_fire && (mmtes_pkg::t_mode'(w_rd.mode) !=
                                       mmtes_pkg::MODE_ONESHOT)) begin
                            o_ram_we    = 1'b1;
                            o_ram_waddr = r_eval_idx;
                            o_ram_wdata = w_wr;
                        end
                        if (w_fire && (r_cnt < mmtes_pkg::CNT_W'(mmtes_pkg::MAX_OUT))) begin
                            if (r_pend_vld) begin
                                o_res_push       = 1'b1;
                                o_res.event_res  = mmtes_pkg::EV_FIRED;
                                o_res.slot_index = mmtes_pkg::slot_out(r_pend_idx);
                            end
                            n_pend_vld = 1'b1;
                            n_pend_idx = r_eval_idx;
                            n_cnt      = r_cnt + 1'b1;
                        end
                    end
                    if (r_issue < (mmtes_pkg::SLOT_W + 1)'(mmtes_pkg::SLOTS)) begin
                        o_ram_re   = 1'b1;
                        n_eval_vld = 1'b1;
                        n_eval_idx = r_issue[mmtes_pkg::SLOT_W-1:0];
                        n_issue    = r_issue + 1'b1;
                    end else begin
                        n_eval_vld = 1'b0;
                        n_state    = mmtes_pkg::ST_FLUSH;
                    end
                end
            end
            mmtes_pkg::ST_FLUSH: begin
                if (!r_pend_vld) begin
                    n_state = mmtes_pkg::ST_IDLE;
                end else if (!i_res_full) begin
                    o_res_push       = 1'b1;
                    o_res.event_res  = mmtes_pkg::EV_FIRED;
                    o_res.slot_index = mmtes_pkg::slot_out(r_pend_idx);
                    o_res.last       = 1'b1;
                    n_pend_vld       = 1'b0;
                    n_state          = mmtes_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = mmtes_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time     <= '0;
            r_valid    <= '0;
            r_eval_vld <= 1'b0;
            r_pend_vld <= 1'b0;
            r_cnt      <= '0;
            r_issue    <= '0;
        end else begin
            r_time     <= n_time;
            r_valid    <= n_valid;
            r_eval_vld <= n_eval_vld;
            r_pend_vld <= n_pend_vld;
            r_cnt      <= n_cnt;
            r_issue    <= n_issue;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cond     <= n_cond;
        r_eval_idx <= n_eval_idx;
        r_pend_idx <= n_pend_idx;
    end

`ifndef SYNTHESIS
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_push |-> !i_res_full)
        else $error("Result request pushed into a full queue.");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= mmtes_pkg::CNT_W'(mmtes_pkg::MAX_OUT))
        else $error("Reported firing count exceeds the limit.");

    a_eval_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_eval_vld |-> (r_state == mmtes_pkg::ST_SCAN))
        else $error("Slot evaluation outside of a scan.");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_state == mmtes_pkg::ST_IDLE) && !r_pend_vld && (r_valid == '0))
        else $error("Reset did not return the sequencer to idle.");
`endif

endmodule

### sv/multi_mode_timer_event_slots.sv
// Timer slot table. A register request is popped from the command queue and its result pushed in the same cycle.
// A tick request steps through a start, one slot memory read per cycle in index order while the
// result queue has room, a step for the last read to return and one to flush the end.
// Requests pass through a two-entry command queue and results through a two-entry result queue.
// Synchronous active-low reset clears the time, all valid bits and both queues at once.
module multi_mode_timer_event_slots (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 push,
    output logic                 full,
    input  mmtes_pkg::t_in_item  i_req,
    output logic                 empty,
    input  logic                 pop,
    output mmtes_pkg::t_out_item o_res
);

    logic                              w_cmd_vld;
    logic                              w_cmd_pop;
    mmtes_pkg::t_cmd                   w_cmd;
    logic                              w_res_full;
    logic                              w_res_push;
    mmtes_pkg::t_out_item              w_res;
    logic                              w_ram_we;
    logic [mmtes_pkg::SLOT_W-1:0]      w_ram_waddr;
    logic [mmtes_pkg::SLOT_WORD_W-1:0] w_ram_wdata;
    logic                              w_ram_re;
    logic [mmtes_pkg::SLOT_W-1:0]      w_ram_raddr;
    logic [mmtes_pkg::SLOT_WORD_W-1:0] w_ram_rdata;

    mmtes_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .o_full    (full),
        .i_req     (i_req),
        .o_cmd_vld (w_cmd_vld),
        .i_cmd_pop (w_cmd_pop),
        .o_cmd     (w_cmd)
    );

    mmtes_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_vld   (w_cmd_vld),
        .i_cmd       (w_cmd),
        .o_cmd_pop   (w_cmd_pop),
        .i_res_full  (w_res_full),
        .o_res_push  (w_res_push),
        .o_res       (w_res),
        .o_ram_we    (w_ram_we),
        .o_ram_waddr (w_ram_waddr),
        .o_ram_wdata (w_ram_wdata),
        .o_ram_re    (w_ram_re),
        .o_ram_raddr (w_ram_raddr),
        .i_ram_rdata (w_ram_rdata)
    );

    mmtes_ram #(
        .WIDTH (mmtes_pkg::SLOT_WORD_W),
        .DEPTH (mmtes_pkg::SLOTS)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_re    (w_ram_re),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    mmtes_out_q u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_res   (w_res),
        .o_full  (w_res_full),
        .o_empty (empty),
        .i_pop   (pop),
        .o_res   (o_res)
    );

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the multi-mode timer slot table.
// Random and directed timer requests are checked against a cycle-free slot model;
// it depends on mmtes_pkg and multi_mode_timer_event_slots.
module testbench;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int LONG_STALL     = 400;
    localparam int RANDOM_ITEMS   = 408;

    logic                 i_clk   = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 push    = 1'b0;
    logic                 pop     = 1'b0;
    logic                 full;
    logic                 empty;
    mmtes_pkg::t_in_item  req_item = '0;
    mmtes_pkg::t_out_item res_item;

    mmtes_pkg::t_in_item  stim_q[$];
    mmtes_pkg::t_out_item expected_events[$];

    logic [mmtes_pkg::TIME_BITS-1:0] model_time;
    logic                            slot_busy [mmtes_pkg::SLOTS];
    logic [1:0]                      slot_kind [mmtes_pkg::SLOTS];
    logic [mmtes_pkg::TIME_BITS-1:0] slot_stop [mmtes_pkg::SLOTS];
    logic [mmtes_pkg::TIME_BITS-1:0] slot_due  [mmtes_pkg::SLOTS];
    logic [mmtes_pkg::TIME_BITS-1:0] slot_step [mmtes_pkg::SLOTS];

    logic [31:0] gen_now = '0;
    int send_wait = 0;
    int pop_wait = 0;
    int stall_left = 0;
    bit long_stall_done = 1'b0;
    int accepted_reqs = 0;
    int tick_reqs = 0;
    int checked_results = 0;
    int fired_cnt = 0;
    int reg_cnt = 0;
    int full_cnt = 0;
    int error_cnt = 0;
    int idle_cycles = 0;

    multi_mode_timer_event_slots dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .full    (full),
        .i_req   (req_item),
        .empty   (empty),
        .pop     (pop),
        .o_res   (res_item)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic deadline_reached(input logic [mmtes_pkg::TIME_BITS-1:0] deadline,
                                              input logic [mmtes_pkg::TIME_BITS-1:0] now);
        logic [mmtes_pkg::TIME_BITS-1:0] diff;
        diff = deadline - now;
        return (diff == '0) || diff[mmtes_pkg::TIME_BITS-1];
    endfunction

    function automatic int pick_gap(input int n);
        int r;
        r = $urandom_range(0, 99);
        if ((n / 32) % 4 == 1) return 0;
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(11, 40);
    endfunction

    // An offset that always lands strictly in the past once the next tick arrives.
    function automatic logic [31:0] far_past();
        return 32'h8000_0001 + $urandom_range(0, 32'h7FFF_FFFE);
    endfunction

    function automatic logic [7:0] cond_pattern();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7) return 8'($urandom | $urandom);
        if (r < 9) return 8'($urandom);
        return 8'($urandom & $urandom);
    endfunction

    task automatic queue_tick(input logic [7:0] cond);
        mmtes_pkg::t_in_item it;
        it = {mmtes_pkg::OP_TICK, 2'($urandom), 32'($urandom), 32'($urandom), cond};
        stim_q.push_back(it);
        gen_now = gen_now + 1;
    endtask

    task automatic queue_timer(input mmtes_pkg::t_mode m, input logic [31:0] tp,
                               input logic [31:0] per);
        mmtes_pkg::t_in_item it;
        it = {mmtes_pkg::OP_REGISTER, m, tp, per, 8'($urandom)};
        stim_q.push_back(it);
    endtask

    task automatic predict_timer_events(input mmtes_pkg::t_in_item r);
        mmtes_pkg::t_out_item ev;
        mmtes_pkg::t_out_item scan_out [mmtes_pkg::MAX_OUT];
        int fired;
        logic due;
        logic fire;
        fired = 0;
        if (r.kind == mmtes_pkg::OP_REGISTER) begin
            ev.event_res = mmtes_pkg::EV_FULL;
            ev.slot_index = 3'd0;
            ev.last = 1'b1;
            for (int s = 0; s < mmtes_pkg::SLOTS; s++) begin
                if (!slot_busy[s] && ev.event_res == mmtes_pkg::EV_FULL) begin
                    slot_busy[s] = 1'b1;
                    slot_kind[s] = r.mode;
                    slot_stop[s] = r.time_point;
                    slot_step[s] = r.period_ticks;
                    slot_due[s] = (r.mode == mmtes_pkg::MODE_ONESHOT) ? r.time_point
                                                                      : model_time;
                    ev.event_res = mmtes_pkg::EV_REGISTERED;
                    ev.slot_index = 3'(s);
                end
            end
            expected_events.push_back(ev);
        end else begin
            model_time = model_time + 1;
            for (int s = 0; s < mmtes_pkg::SLOTS; s++) begin
                if (slot_busy[s]) begin
                    due = deadline_reached(slot_due[s], model_time);
                    fire = 1'b0;
                    case (slot_kind[s])
                        mmtes_pkg::MODE_ONESHOT: begin
                            if (due) begin
                                fire = 1'b1;
                                slot_busy[s] = 1'b0;
                            end
                        end
                        mmtes_pkg::MODE_PERIODIC: fire = due;
                        mmtes_pkg::MODE_UNTIL: begin
                            if (deadline_reached(slot_stop[s], model_time)) slot_busy[s] = 1'b0;
                            else fire = due;
                        end
                        default: begin
                            if (due) begin
                                if (r.condition_bits[s]) fire = 1'b1;
                                else slot_busy[s] = 1'b0;
                            end
                        end
                    endcase
                    if (fire) begin
                        if (slot_kind[s] != mmtes_pkg::MODE_ONESHOT)
                            slot_due[s] = model_time + slot_step[s];
                        if (fired < mmtes_pkg::MAX_OUT) begin
                            scan_out[fired].event_res = mmtes_pkg::EV_FIRED;
                            scan_out[fired].slot_index = 3'(s);
                            scan_out[fired].last = 1'b0;
                            fired++;
                        end
                    end
                end
            end
            for (int k = 0; k < fired; k++) begin
                ev = scan_out[k];
                ev.last = (k == fired - 1);
                expected_events.push_back(ev);
            end
        end
    endtask

    always @(negedge i_clk) begin
        if (!i_rst_n || stim_q.size() == 0) begin
            push <= 1'b0;
        end else if (send_wait > 0) begin
            send_wait--;
            push <= 1'b0;
        end else begin
            push <= 1'b1;
            req_item <= stim_q[0];
        end
    end

    // The receiver holds off once for a long stretch so that both queues fill.
    always @(negedge i_clk) begin
        if (!long_stall_done && accepted_reqs >= 60) begin
            long_stall_done = 1'b1;
            stall_left = LONG_STALL;
        end
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            pop <= 1'b0;
        end else if (pop_wait > 0) begin
            pop_wait--;
            pop <= 1'b0;
        end else begin
            pop <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        mmtes_pkg::t_out_item want;
        if (i_rst_n) begin
            if (pop && !empty) begin
                checked_results++;
                case (res_item.event_res)
                    mmtes_pkg::EV_FIRED:      fired_cnt++;
                    mmtes_pkg::EV_REGISTERED: reg_cnt++;
                    default:                  full_cnt++;
                endcase
                if (expected_events.size() == 0) begin
                    error_cnt++;
                    if (error_cnt <= 10)
                        $display("tb: result with none expected: res=%0d slot=%0d last=%0d",
                                 res_item.event_res, res_item.slot_index, res_item.last);
                end else begin
                    want = expected_events.pop_front();
                    if (want.event_res !== res_item.event_res ||
                        want.slot_index !== res_item.slot_index ||
                        want.last !== res_item.last) begin
                        error_cnt++;
                        if (error_cnt <= 10) begin
                            $display("tb: mismatch on result %0d: expected res=%0d slot=%0d last=%0d",
                                     checked_results, want.event_res, want.slot_index,
                                     want.last);
                            $display("tb:     got res=%0d slot=%0d last=%0d",
                                     res_item.event_res, res_item.slot_index, res_item.last);
                        end
                    end
                end
                pop_wait = pick_gap(checked_results);
            end
            if (push && !full) begin
                predict_timer_events(req_item);
                if (req_item.kind == mmtes_pkg::OP_TICK) tick_reqs++;
                void'(stim_q.pop_front());
                accepted_reqs++;
                send_wait = pick_gap(accepted_reqs);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((push && !full) || (pop && !empty)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("tb: no progress for %0d cycles", WATCHDOG_LIMIT);
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial begin
        int pick;
        int periodic_left;
        periodic_left = 2;
        model_time = '0;
        for (int s = 0; s < mmtes_pkg::SLOTS; s++) slot_busy[s] = 1'b0;

        // Fill the table with conditional timers, overflow it, then drain it by condition.
        for (int s = 0; s < mmtes_pkg::SLOTS; s++)
            queue_timer(mmtes_pkg::MODE_WHILE, $urandom, 32'd0);
        queue_timer(mmtes_pkg::MODE_ONESHOT, gen_now + 1, 32'd0);
        queue_tick(8'hFF);
        queue_tick(8'hA5);
        queue_tick(8'h00);
        // Deadlines at both ends of the field and at the edge of the signed window.
        queue_timer(mmtes_pkg::MODE_ONESHOT, 32'h0000_0000, 32'hFFFF_FFFF);
        queue_timer(mmtes_pkg::MODE_ONESHOT, gen_now + 32'h8000_0001, 32'h0000_0000);
        queue_timer(mmtes_pkg::MODE_PERIODIC, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_timer(mmtes_pkg::MODE_UNTIL, gen_now + 1, 32'd1);
        queue_timer(mmtes_pkg::MODE_UNTIL, gen_now + 3, 32'd1);
        queue_timer(mmtes_pkg::MODE_ONESHOT, gen_now + 2, 32'd7);
        repeat (4) queue_tick(cond_pattern());

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                queue_tick(cond_pattern());
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 30) begin
                    if ($urandom_range(0, 9) < 7)
                        queue_timer(mmtes_pkg::MODE_ONESHOT, gen_now + $urandom_range(0, 12),
                                    $urandom);
                    else
                        queue_timer(mmtes_pkg::MODE_ONESHOT, gen_now + far_past(), $urandom);
                end else if (pick < 60) begin
                    queue_timer(mmtes_pkg::MODE_UNTIL, gen_now + $urandom_range(0, 20),
                                ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 5));
                end else if (pick < 95 || periodic_left == 0) begin
                    queue_timer(mmtes_pkg::MODE_WHILE, $urandom,
                                ($urandom_range(0, 9) < 7) ? $urandom_range(0, 5) : far_past());
                end else begin
                    periodic_left--;
                    queue_timer(mmtes_pkg::MODE_PERIODIC, $urandom,
                                $urandom_range(0, 1) ? 32'hFFFF_FFFF : $urandom_range(1, 4));
                end
            end
        end

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        while (stim_q.size() != 0 || expected_events.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);

        $display("tb: %0d requests driven, %0d of them ticks and %0d timer registrations",
                 accepted_reqs, tick_reqs, accepted_reqs - tick_reqs);
        $display("tb: %0d results checked (%0d fired, %0d registered, %0d table full), %0d errors",
                 checked_results, fired_cnt, reg_cnt, full_cnt, error_cnt);
        if (error_cnt == 0 && expected_events.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
